// ===== design/wrlm_pkg.sv =====
// Shared types, constants and helper functions of the rate and latency monitor.
package wrlm_pkg;

    // Window lengths in seconds.
    localparam int SHORT_WINDOW = 60;
    localparam int MID_WINDOW   = 300;
    localparam int LONG_WINDOW  = 900;

    // Effective window lengths, clamped to the history depth and to at least one.
    localparam int W_SHORT = (SHORT_WINDOW > LONG_WINDOW) ? LONG_WINDOW :
                             (SHORT_WINDOW < 1) ? 1 : SHORT_WINDOW;
    localparam int W_MID   = (MID_WINDOW > LONG_WINDOW) ? LONG_WINDOW :
                             (MID_WINDOW < 1) ? 1 : MID_WINDOW;
    localparam int W_LONG  = (LONG_WINDOW < 1) ? 1 : LONG_WINDOW;

    // Field widths.
    localparam int KIND_W = 2;
    localparam int LEN_W  = 32;
    localparam int LAT_W  = 32;
    localparam int RATE_W = 24;
    localparam int TOT_W  = 48;
    localparam int WIN_W  = 2;
    localparam int DLY_W  = LAT_W + 8;

    // History and sum widths.
    localparam int FILL_W = $clog2(LONG_WINDOW + 1);
    localparam int ADDR_W = $clog2(LONG_WINDOW);
    localparam int RSUM_W = RATE_W + FILL_W;
    localparam int DSUM_W = DLY_W + FILL_W;
    localparam int LSUM_W = 64;

    // Divider widths.
    localparam int DIVD_W = 64;
    localparam int DIVS_W = 24;
    localparam int DCNT_W = $clog2(DIVD_W);

    // Event kinds.
    localparam logic [KIND_W-1:0] KIND_REQ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    // Window indexes.
    localparam logic [WIN_W-1:0] WIN_SHORT = 2'd0;
    localparam logic [WIN_W-1:0] WIN_MID   = 2'd1;
    localparam logic [WIN_W-1:0] WIN_LONG  = 2'd2;

    typedef enum logic [1:0] {
        HIST_RATE,
        HIST_BUSY,
        HIST_DELAY
    } hist_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_READ,
        OP_UPDATE,
        OP_WRITE,
        OP_DIV_WIN,
        OP_STORE_WIN,
        OP_DIV_LAT,
        OP_STORE_LAT
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        hist_t            hist;
        logic [WIN_W-1:0] win;
    } dp_cmd_t;

    typedef struct packed {
        logic rate_nz;
        logic lat_go;
        logic div_done;
    } dp_status_t;

    // Window length for a window index.
    function automatic logic [FILL_W-1:0] win_len(input logic [WIN_W-1:0] k);
        logic [FILL_W-1:0] w;
        case (k)
            WIN_SHORT: w = FILL_W'(W_SHORT);
            WIN_MID:   w = FILL_W'(W_MID);
            default:   w = FILL_W'(W_LONG);
        endcase
        return w;
    endfunction

    // Distance forward from the write slot to the entry leaving a window.
    function automatic logic [ADDR_W:0] win_back(input logic [WIN_W-1:0] k);
        logic [ADDR_W:0] d;
        case (k)
            WIN_SHORT: d = (ADDR_W+1)'(LONG_WINDOW - W_SHORT);
            WIN_MID:   d = (ADDR_W+1)'(LONG_WINDOW - W_MID);
            default:   d = (ADDR_W+1)'(LONG_WINDOW - W_LONG);
        endcase
        return d;
    endfunction

endpackage

// ===== design/wrlm_if.sv =====
// Handshake channels for events in and results out.
interface wrlm_in_if;
    logic                           valid;
    logic                           ready;
    logic [wrlm_pkg::KIND_W-1:0]    kind;
    logic [wrlm_pkg::LEN_W-1:0]     length_bytes;
    logic                           has_timing;
    logic [wrlm_pkg::LAT_W-1:0]     latency_us;

    modport source (output valid, kind, length_bytes, has_timing, latency_us, input ready);
    modport sink   (input valid, kind, length_bytes, has_timing, latency_us, output ready);
endinterface

interface wrlm_out_if;
    logic                           valid;
    logic                           ready;
    logic [wrlm_pkg::WIN_W-1:0]     window;
    logic [wrlm_pkg::RATE_W-1:0]    sustained_rate;
    logic [wrlm_pkg::RATE_W-1:0]    attained_rate;
    logic [wrlm_pkg::LAT_W-1:0]     mean_latency_us;
    logic [wrlm_pkg::RATE_W-1:0]    peak_rate;
    logic [wrlm_pkg::LAT_W-1:0]     peak_latency_us;
    logic [wrlm_pkg::TOT_W-1:0]     total_served;
    logic [wrlm_pkg::TOT_W-1:0]     bytes_in;
    logic [wrlm_pkg::TOT_W-1:0]     bytes_out;
    logic                           last;

    modport source (output valid, window, sustained_rate, attained_rate, mean_latency_us,
                    peak_rate, peak_latency_us, total_served, bytes_in, bytes_out, last,
                    input ready);
    modport sink   (input valid, window, sustained_rate, attained_rate, mean_latency_us,
                    peak_rate, peak_latency_us, total_served, bytes_in, bytes_out, last,
                    output ready);
endinterface

// ===== design/wrlm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module wrlm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wrlm_pkg::DIVD_W-1:0]   dividend,
    input  logic [wrlm_pkg::DIVS_W-1:0]   divisor,
    output logic [wrlm_pkg::DIVD_W-1:0]   quotient,
    output logic                          done
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [wrlm_pkg::DCNT_W-1:0]   cnt_reg;
    logic [wrlm_pkg::DIVD_W-1:0]   quo_reg;
    logic [wrlm_pkg::DIVD_W-1:0]   quo_next;
    logic [wrlm_pkg::DIVS_W-1:0]   rem_reg;
    logic [wrlm_pkg::DIVS_W-1:0]   rem_next;
    logic [wrlm_pkg::DIVS_W-1:0]   dvs_reg;
    logic [wrlm_pkg::DIVS_W:0]     trial;
    logic                          ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[wrlm_pkg::DIVD_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? wrlm_pkg::DIVS_W'(trial - {1'b0, dvs_reg})
                      : wrlm_pkg::DIVS_W'(trial);
        quo_next = {quo_reg[wrlm_pkg::DIVD_W-2:0], ge};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == wrlm_pkg::DCNT_W'(wrlm_pkg::DIVD_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== design/wrlm_ctrl.sv =====
// Sequencer: takes items, walks the history pushes, divisions and result emission.
module wrlm_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [wrlm_pkg::KIND_W-1:0]   in_kind,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  wrlm_pkg::dp_status_t          status,
    output wrlm_pkg::dp_cmd_t             cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_UPD,
        ST_WR,
        ST_DSTART,
        ST_DWAIT,
        ST_LSTART,
        ST_LWAIT,
        ST_EMIT
    } state_t;

    state_t                       state_reg;
    wrlm_pkg::hist_t              hist_reg;
    logic [wrlm_pkg::WIN_W-1:0]   win_reg;

    // Command decode
    always_comb
    begin
        cmd.op   = wrlm_pkg::OP_NONE;
        cmd.hist = hist_reg;
        cmd.win  = win_reg;
        case (state_reg)
            ST_IDLE:   cmd.op = in_valid ? wrlm_pkg::OP_ACCEPT : wrlm_pkg::OP_NONE;
            ST_RD:     cmd.op = wrlm_pkg::OP_READ;
            ST_UPD:    cmd.op = wrlm_pkg::OP_UPDATE;
            ST_WR:     cmd.op = wrlm_pkg::OP_WRITE;
            ST_DSTART: cmd.op = wrlm_pkg::OP_DIV_WIN;
            ST_DWAIT:  cmd.op = status.div_done ? wrlm_pkg::OP_STORE_WIN : wrlm_pkg::OP_NONE;
            ST_LSTART: cmd.op = wrlm_pkg::OP_DIV_LAT;
            ST_LWAIT:  cmd.op = status.div_done ? wrlm_pkg::OP_STORE_LAT : wrlm_pkg::OP_NONE;
            default:   cmd.op = wrlm_pkg::OP_NONE;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    // State, history and window index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hist_reg  <= wrlm_pkg::HIST_RATE;
            win_reg   <= wrlm_pkg::WIN_SHORT;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_kind == wrlm_pkg::KIND_TICK)
                    begin
                        hist_reg  <= wrlm_pkg::HIST_RATE;
                        win_reg   <= wrlm_pkg::WIN_SHORT;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                    state_reg <= ST_UPD;
                ST_UPD:
                begin
                    if (win_reg == wrlm_pkg::WIN_LONG)
                    begin
                        win_reg   <= wrlm_pkg::WIN_SHORT;
                        state_reg <= ST_WR;
                    end
                    else
                    begin
                        win_reg   <= win_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_WR:
                    state_reg <= ST_DSTART;
                ST_DSTART:
                    state_reg <= ST_DWAIT;
                ST_DWAIT:
                begin
                    if (status.div_done)
                    begin
                        if (win_reg != wrlm_pkg::WIN_LONG)
                        begin
                            win_reg   <= win_reg + 1'b1;
                            state_reg <= ST_DSTART;
                        end
                        else
                        begin
                            win_reg <= wrlm_pkg::WIN_SHORT;
                            // pick the next history, or the latency division, or emit
                            if (hist_reg == wrlm_pkg::HIST_RATE && status.rate_nz)
                            begin
                                hist_reg  <= wrlm_pkg::HIST_BUSY;
                                state_reg <= ST_RD;
                            end
                            else if (hist_reg != wrlm_pkg::HIST_DELAY && status.lat_go)
                                state_reg <= ST_LSTART;
                            else
                                state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_LSTART:
                    state_reg <= ST_LWAIT;
                ST_LWAIT:
                begin
                    if (status.div_done)
                    begin
                        hist_reg  <= wrlm_pkg::HIST_DELAY;
                        win_reg   <= wrlm_pkg::WIN_SHORT;
                        state_reg <= ST_RD;
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        if (win_reg == wrlm_pkg::WIN_LONG)
                        begin
                            win_reg   <= wrlm_pkg::WIN_SHORT;
                            state_reg <= ST_IDLE;
                        end
                        else
                            win_reg <= win_reg + 1'b1;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== design/wrlm_dp.sv =====
// Datapath: counters, history memories, window sums, means and the divider.
module wrlm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wrlm_pkg::dp_cmd_t             cmd,
    output wrlm_pkg::dp_status_t          status,
    input  logic [wrlm_pkg::KIND_W-1:0]   kind,
    input  logic [wrlm_pkg::LEN_W-1:0]    length_bytes,
    input  logic                          has_timing,
    input  logic [wrlm_pkg::LAT_W-1:0]    latency_us,
    output logic [wrlm_pkg::WIN_W-1:0]    window,
    output logic [wrlm_pkg::RATE_W-1:0]   sustained_rate,
    output logic [wrlm_pkg::RATE_W-1:0]   attained_rate,
    output logic [wrlm_pkg::LAT_W-1:0]    mean_latency_us,
    output logic [wrlm_pkg::RATE_W-1:0]   peak_rate,
    output logic [wrlm_pkg::LAT_W-1:0]    peak_latency_us,
    output logic [wrlm_pkg::TOT_W-1:0]    total_served,
    output logic [wrlm_pkg::TOT_W-1:0]    bytes_in,
    output logic [wrlm_pkg::TOT_W-1:0]    bytes_out,
    output logic                          last
);

    localparam int RW = wrlm_pkg::RATE_W;
    localparam int DW = wrlm_pkg::DLY_W;
    localparam int AW = wrlm_pkg::ADDR_W;
    localparam int FW = wrlm_pkg::FILL_W;

    // Per-second counters and totals
    logic [RW-1:0]                 count_reg;
    logic [wrlm_pkg::LSUM_W-1:0]   lat_sum_reg;
    logic [RW-1:0]                 samples_reg;
    logic [RW-1:0]                 rate_reg;
    logic                          lat_go_reg;
    logic [DW-1:0]                 avg_reg;
    logic [RW-1:0]                 peak_rate_reg;
    logic [wrlm_pkg::LAT_W-1:0]    peak_delay_reg;
    logic [wrlm_pkg::TOT_W-1:0]    served_reg;
    logic [wrlm_pkg::TOT_W-1:0]    bytes_in_reg;
    logic [wrlm_pkg::TOT_W-1:0]    bytes_out_reg;

    // History bookkeeping, indexed by history
    logic [AW-1:0]                 slot_reg [3];
    logic [FW-1:0]                 fill_reg [3];
    logic [wrlm_pkg::RSUM_W-1:0]   rate_sum_reg  [3];
    logic [wrlm_pkg::RSUM_W-1:0]   busy_sum_reg  [3];
    logic [wrlm_pkg::DSUM_W-1:0]   delay_sum_reg [3];
    logic [RW-1:0]                 sust_mean_reg  [3];
    logic [RW-1:0]                 busy_mean_reg  [3];
    logic [DW-1:0]                 delay_mean_reg [3];

    // Memories
    logic [RW-1:0]                 rate_mem  [wrlm_pkg::LONG_WINDOW];
    logic [RW-1:0]                 busy_mem  [wrlm_pkg::LONG_WINDOW];
    logic [DW-1:0]                 delay_mem [wrlm_pkg::LONG_WINDOW];
    logic [RW-1:0]                 rate_rd_reg;
    logic [RW-1:0]                 busy_rd_reg;
    logic [DW-1:0]                 delay_rd_reg;

    // Selected history values
    logic [AW-1:0]                 slot_cur;
    logic [FW-1:0]                 fill_cur;
    logic [FW-1:0]                 wlen;
    logic [AW:0]                   back_sum;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 slot_adv;
    logic [DW-1:0]                 push_val;
    logic [DW-1:0]                 rd_val;
    logic [wrlm_pkg::DSUM_W-1:0]   sum_cur;
    logic [wrlm_pkg::DSUM_W-1:0]   sum_new;
    logic                          full_win;
    logic [FW-1:0]                 divisor_win;
    logic                          we_rate;
    logic                          we_busy;
    logic                          we_delay;

    // Divider hookup
    logic                          div_start;
    logic [wrlm_pkg::DIVD_W-1:0]   div_dividend;
    logic [wrlm_pkg::DIVS_W-1:0]   div_divisor;
    logic [wrlm_pkg::DIVD_W-1:0]   div_quotient;
    logic                          div_done;

    // History select and window arithmetic
    always_comb
    begin
        slot_cur = slot_reg[cmd.hist];
        fill_cur = fill_reg[cmd.hist];
        wlen     = wrlm_pkg::win_len(cmd.win);
        back_sum = {1'b0, slot_cur} + wrlm_pkg::win_back(cmd.win);
        if (back_sum >= (AW+1)'(wrlm_pkg::LONG_WINDOW))
            rd_addr = AW'(back_sum - (AW+1)'(wrlm_pkg::LONG_WINDOW));
        else
            rd_addr = AW'(back_sum);
        if ({1'b0, slot_cur} == (AW+1)'(wrlm_pkg::LONG_WINDOW - 1))
            slot_adv = '0;
        else
            slot_adv = slot_cur + 1'b1;
        full_win    = fill_cur >= wlen;
        divisor_win = (fill_cur < wlen) ? fill_cur : wlen;
        case (cmd.hist)
            wrlm_pkg::HIST_RATE:
            begin
                push_val = DW'(rate_reg);
                rd_val   = DW'(rate_rd_reg);
                sum_cur  = wrlm_pkg::DSUM_W'(rate_sum_reg[cmd.win]);
            end
            wrlm_pkg::HIST_BUSY:
            begin
                push_val = DW'(rate_reg);
                rd_val   = DW'(busy_rd_reg);
                sum_cur  = wrlm_pkg::DSUM_W'(busy_sum_reg[cmd.win]);
            end
            default:
            begin
                push_val = avg_reg;
                rd_val   = delay_rd_reg;
                sum_cur  = delay_sum_reg[cmd.win];
            end
        endcase
        sum_new = sum_cur - (full_win ? wrlm_pkg::DSUM_W'(rd_val) : '0)
                  + wrlm_pkg::DSUM_W'(push_val);
        we_rate  = (cmd.op == wrlm_pkg::OP_WRITE) && (cmd.hist == wrlm_pkg::HIST_RATE);
        we_busy  = (cmd.op == wrlm_pkg::OP_WRITE) && (cmd.hist == wrlm_pkg::HIST_BUSY);
        we_delay = (cmd.op == wrlm_pkg::OP_WRITE) && (cmd.hist == wrlm_pkg::HIST_DELAY);
    end

    // Divider operands: a window mean or the latency mean of the second
    always_comb
    begin
        div_start = (cmd.op == wrlm_pkg::OP_DIV_WIN) || (cmd.op == wrlm_pkg::OP_DIV_LAT);
        if (cmd.op == wrlm_pkg::OP_DIV_LAT)
        begin
            div_dividend = {lat_sum_reg[wrlm_pkg::DIVD_W-9:0], 8'h00};
            div_divisor  = samples_reg;
        end
        else
        begin
            div_dividend = wrlm_pkg::DIVD_W'(sum_cur);
            div_divisor  = wrlm_pkg::DIVS_W'(divisor_win);
        end
    end

    wrlm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // History memories, read data registered
    always_ff @(posedge clk)
    begin
        if (we_rate)
            rate_mem[slot_cur] <= RW'(push_val);
        if (we_busy)
            busy_mem[slot_cur] <= RW'(push_val);
        if (we_delay)
            delay_mem[slot_cur] <= push_val;
        rate_rd_reg  <= rate_mem[rd_addr];
        busy_rd_reg  <= busy_mem[rd_addr];
        delay_rd_reg <= delay_mem[rd_addr];
    end

    // Counters, totals and history state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            lat_sum_reg    <= '0;
            samples_reg    <= '0;
            rate_reg       <= '0;
            lat_go_reg     <= 1'b0;
            avg_reg        <= '0;
            peak_rate_reg  <= '0;
            peak_delay_reg <= '0;
            served_reg     <= '0;
            bytes_in_reg   <= '0;
            bytes_out_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                slot_reg[i]       <= '0;
                fill_reg[i]       <= '0;
                rate_sum_reg[i]   <= '0;
                busy_sum_reg[i]   <= '0;
                delay_sum_reg[i]  <= '0;
                sust_mean_reg[i]  <= '0;
                busy_mean_reg[i]  <= '0;
                delay_mean_reg[i] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                wrlm_pkg::OP_ACCEPT:
                begin
                    case (kind)
                        wrlm_pkg::KIND_REQ:
                            bytes_in_reg <= bytes_in_reg + wrlm_pkg::TOT_W'(length_bytes);
                        wrlm_pkg::KIND_RESP:
                        begin
                            bytes_out_reg <= bytes_out_reg + wrlm_pkg::TOT_W'(length_bytes);
                            served_reg    <= served_reg + 1'b1;
                            if (has_timing)
                            begin
                                // sum and samples saturate together
                                if (samples_reg != '1)
                                begin
                                    lat_sum_reg <= lat_sum_reg
                                                   + wrlm_pkg::LSUM_W'(latency_us);
                                    samples_reg <= samples_reg + 1'b1;
                                end
                                if (count_reg != '1)
                                    count_reg <= count_reg + 1'b1;
                                if (latency_us > peak_delay_reg && peak_rate_reg != '0)
                                    peak_delay_reg <= latency_us;
                            end
                        end
                        wrlm_pkg::KIND_TICK:
                        begin
                            rate_reg   <= count_reg;
                            count_reg  <= '0;
                            lat_go_reg <= (lat_sum_reg != '0) && (samples_reg != '0);
                            if (count_reg > peak_rate_reg)
                                peak_rate_reg <= count_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                wrlm_pkg::OP_UPDATE:
                begin
                    case (cmd.hist)
                        wrlm_pkg::HIST_RATE:
                            rate_sum_reg[cmd.win] <= wrlm_pkg::RSUM_W'(sum_new);
                        wrlm_pkg::HIST_BUSY:
                            busy_sum_reg[cmd.win] <= wrlm_pkg::RSUM_W'(sum_new);
                        default:
                            delay_sum_reg[cmd.win] <= sum_new;
                    endcase
                end
                wrlm_pkg::OP_WRITE:
                begin
                    slot_reg[cmd.hist] <= slot_adv;
                    if (fill_cur < FW'(wrlm_pkg::LONG_WINDOW))
                        fill_reg[cmd.hist] <= fill_cur + 1'b1;
                end
                wrlm_pkg::OP_STORE_WIN:
                begin
                    case (cmd.hist)
                        wrlm_pkg::HIST_RATE:
                            sust_mean_reg[cmd.win] <= RW'(div_quotient);
                        wrlm_pkg::HIST_BUSY:
                            busy_mean_reg[cmd.win] <= RW'(div_quotient);
                        default:
                            delay_mean_reg[cmd.win] <= DW'(div_quotient);
                    endcase
                end
                wrlm_pkg::OP_DIV_LAT:
                begin
                    lat_sum_reg <= '0;
                    samples_reg <= '0;
                end
                wrlm_pkg::OP_STORE_LAT:
                    avg_reg <= DW'(div_quotient);
                default:
                begin
                end
            endcase
        end
    end

    assign status.rate_nz  = (rate_reg != '0);
    assign status.lat_go   = lat_go_reg;
    assign status.div_done = div_done;

    // Result fields for the window being emitted
    assign window          = cmd.win;
    assign sustained_rate  = sust_mean_reg[cmd.win];
    assign attained_rate   = busy_mean_reg[cmd.win];
    assign mean_latency_us = delay_mean_reg[cmd.win][DW-1:8];
    assign peak_rate       = peak_rate_reg;
    assign peak_latency_us = peak_delay_reg;
    assign total_served    = served_reg;
    assign bytes_in        = bytes_in_reg;
    assign bytes_out       = bytes_out_reg;
    assign last            = (cmd.win == wrlm_pkg::WIN_LONG);

endmodule

// ===== design/windowed_rate_latency_monitor.sv =====
// Request and response items are handled in the idle state. Before the first result, a
// tick runs, per history pushed, a read and an update for each window, one write and
// three divisions in the shared 64-step divider, plus one latency division if samples
// are pending. Then one result per cycle as the sink takes them; one item at a time.
// Reset (rst_n, async, active low) clears counters, sums, means and fill counts;
// history memories are not cleared; their read data is used only once written.
module windowed_rate_latency_monitor (
    input  logic        clk,
    input  logic        rst_n,
    wrlm_in_if.sink     events,
    wrlm_out_if.source  results
);

    wrlm_pkg::dp_cmd_t     cmd;
    wrlm_pkg::dp_status_t  status;

    wrlm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (events.valid),
        .in_kind   (events.kind),
        .in_ready  (events.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    wrlm_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .kind            (events.kind),
        .length_bytes    (events.length_bytes),
        .has_timing      (events.has_timing),
        .latency_us      (events.latency_us),
        .window          (results.window),
        .sustained_rate  (results.sustained_rate),
        .attained_rate   (results.attained_rate),
        .mean_latency_us (results.mean_latency_us),
        .peak_rate       (results.peak_rate),
        .peak_latency_us (results.peak_latency_us),
        .total_served    (results.total_served),
        .bytes_in        (results.bytes_in),
        .bytes_out       (results.bytes_out),
        .last            (results.last)
    );

    // No new item is taken while results are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> !events.ready)
        else $error("item accepted during result emission");

    // After the last result is taken the block returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.ready && results.last |=> !results.valid && events.ready)
        else $error("results continued past the last window");

    // A result burst always starts with the short window
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> results.window == wrlm_pkg::WIN_SHORT)
        else $error("result burst did not start at the short window");

endmodule
